/* sv/mhrb_pkg.sv */
package mhrb_pkg;

	// Default sizes for the top-level parameters
	localparam int DEPTH_DEF        = 4096;
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int MAX_READ_DEF     = 64;
	localparam int SAMPLE_BITS_DEF  = 24;

	// Register values after reset
	localparam int CHANNELS_RST      = 2;
	localparam int BUFFER_LENGTH_RST = 4096;

	// Item kinds carried on s_tuser
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_CHANNELS      = 2'd0;
	localparam logic [1:0] REG_BUFFER_LENGTH = 2'd1;

	// Result range, signed 27 bits
	localparam longint OUT_MAX = 67108863;
	localparam longint OUT_MIN = -67108864;

	// Result queue depth
	localparam int OUT_DEPTH = 4;

	// Input word, last field in the lowest bits
	typedef struct packed {
		logic        sum_all;
		logic [6:0]  count;
		logic [12:0] delay;
		logic [23:0] sample_in;
		logic [2:0]  channel;
	} item_t;

	// Result word as it waits in the output queue
	typedef struct packed {
		logic               last;
		logic               empty_res;
		logic [12:0]        filled;
		logic signed [26:0] sample_out;
	} out_word_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_AIM   = 5'b00100,
		ST_ISSUE = 5'b01000,
		ST_CLEAR = 5'b10000
	} state_t;

	typedef struct packed {
		logic accept;
		logic restart;
		logic prep;
		logic aim;
		logic issue;
		logic sweep;
	} cmd_t;

	typedef struct packed {
		logic room;
		logic last;
		logic sweep_end;
	} status_t;

endpackage

/* sv/mhrb_ram.sv */
module mhrb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/mhrb_ctrl.sv */
module mhrb_ctrl
	import mhrb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] kind,
	input  logic       cfg_len_wr,
	input  status_t    st,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (kind == KIND_READ) begin
						state_d = ST_PREP;
					end else if (kind == KIND_CLEAR) begin
						cmd.restart = 1'b1;
						state_d     = ST_CLEAR;
					end
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_AIM;
			end
			ST_AIM: begin
				cmd.aim = 1'b1;
				state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (st.room) begin
					cmd.issue = 1'b1;
					if (st.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (st.sweep_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		// a new ring length empties the ring from any state
		if (cfg_len_wr) begin
			cmd.restart = 1'b1;
			state_d     = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/mhrb_dp.sv */
module mhrb_dp
	import mhrb_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_READ     = MAX_READ_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output status_t    st,
	input  logic [1:0] kind,
	input  item_t      item,
	input  logic       frame_end,
	input  logic       cfg_wr,
	input  logic [1:0] cfg_index,
	input  logic [12:0] cfg_data,
	output logic       m_tvalid,
	input  logic       m_tready,
	output out_word_t  m_word
);

	localparam int AW  = $clog2(DEPTH);
	localparam int LW  = $clog2(DEPTH + 1);
	localparam int CHW = $clog2(MAX_CHANNELS + 1);
	localparam int H   = (MAX_CHANNELS + 1) / 2;
	localparam int HW  = SAMPLE_BITS + $clog2(H + 1);
	localparam int XW  = (HW + 1 > 28) ? HW + 1 : 28;
	localparam int FPW = $clog2(OUT_DEPTH);
	localparam int FCW = $clog2(OUT_DEPTH + 1);
	localparam int NCH_RST = (CHANNELS_RST > MAX_CHANNELS) ? MAX_CHANNELS : CHANNELS_RST;
	localparam int LEN_RST = (BUFFER_LENGTH_RST > DEPTH) ? DEPTH : BUFFER_LENGTH_RST;
	localparam logic signed [XW-1:0] SAT_HI = XW'(OUT_MAX);
	localparam logic signed [XW-1:0] SAT_LO = XW'(OUT_MIN);

	// configuration, kept in clamped form
	logic [CHW-1:0] nch_q;
	logic [LW-1:0]  len_q;

	// ring state
	logic [AW-1:0]  pos_q;
	logic [LW-1:0]  fill_q;
	logic [AW-1:0]  sweep_q;

	// read request
	logic [2:0]     ch_q;
	logic [12:0]    delay_q;
	logic [6:0]     count_q;
	logic           sum_q;
	logic [6:0]     n_q;
	logic [LW-1:0]  dmin_q;
	logic           empty_q;
	logic [AW-1:0]  addr_q;
	logic [6:0]     k_q;
	logic           last_now;

	// result pipeline
	logic           v_s1, last_s1, empty_s1, sum_s1;
	logic [2:0]     ch_s1;
	logic [12:0]    filled_s1;
	logic           v_s2, last_s2, empty_s2;
	logic [12:0]    filled_s2;
	logic signed [HW-1:0] half0_s2, half1_s2;
	logic signed [HW-1:0] half0, half1;
	logic signed [XW-1:0] sum_x;
	logic signed [26:0]   sat;

	// result queue
	out_word_t      fifo_q [OUT_DEPTH];
	logic [FPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCW-1:0] cnt_q;
	logic           pop;
	logic [FCW:0]   pend;

	logic signed [SAMPLE_BITS-1:0] rdata [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0]       lane_we;
	logic                          write_item;
	logic [AW-1:0]                 ram_waddr;
	logic [SAMPLE_BITS-1:0]        ram_wdata;

	assign write_item = cmd.accept && (kind == KIND_WRITE);
	assign ram_waddr  = cmd.sweep ? sweep_q : pos_q;
	assign ram_wdata  = cmd.sweep ? '0 : SAMPLE_BITS'($signed(item.sample_in));

	always_comb begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			lane_we[c] = cmd.sweep || (write_item && (int'(item.channel) == c)
				&& (int'(item.channel) < int'(nch_q)));
		end
	end

	for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
		mhrb_ram #(
			.WIDTH(SAMPLE_BITS),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (lane_we[g]),
			.waddr(ram_waddr),
			.wdata(ram_wdata),
			.re   (cmd.issue),
			.raddr(addr_q),
			.rdata(rdata[g])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nch_q <= CHW'(NCH_RST);
			len_q <= LW'(LEN_RST);
		end else if (cfg_wr) begin
			if (cfg_index == REG_CHANNELS) begin
				if (cfg_data[3:0] == 4'd0) begin
					nch_q <= CHW'(1);
				end else if (int'(cfg_data[3:0]) > MAX_CHANNELS) begin
					nch_q <= CHW'(MAX_CHANNELS);
				end else begin
					nch_q <= CHW'(cfg_data[3:0]);
				end
			end else if (cfg_index == REG_BUFFER_LENGTH) begin
				if (cfg_data == 13'd0) begin
					len_q <= LW'(1);
				end else if (int'(cfg_data) > DEPTH) begin
					len_q <= LW'(DEPTH);
				end else begin
					len_q <= LW'(cfg_data);
				end
			end
		end
	end

	// write position, fill count and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fill_q  <= '0;
			sweep_q <= '0;
		end else if (cmd.restart) begin
			pos_q   <= '0;
			fill_q  <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.sweep) begin
				sweep_q <= AW'(sweep_q + 1'b1);
			end
			if (write_item && frame_end) begin
				if (LW'(pos_q) + LW'(1) >= len_q) begin
					pos_q <= '0;
				end else begin
					pos_q <= AW'(pos_q + 1'b1);
				end
				if (fill_q < len_q) begin
					fill_q <= LW'(fill_q + 1'b1);
				end
			end
		end
	end

	assign st.sweep_end = (sweep_q == AW'(DEPTH - 1));

	// read setup: capture, clamp length, then find the first frame
	always_ff @(posedge clk) begin
		int n_i;
		int back_i;
		int start_i;
		n_i     = 0;
		back_i  = 0;
		start_i = 0;
		if (cmd.accept) begin
			ch_q    <= item.channel;
			delay_q <= item.delay;
			count_q <= item.count;
			sum_q   <= item.sum_all;
		end
		if (cmd.prep) begin
			n_i = int'(count_q);
			if (int'(fill_q) < n_i) n_i = int'(fill_q);
			if (MAX_READ < n_i) n_i = MAX_READ;
			n_q     <= 7'(n_i);
			dmin_q  <= (int'(delay_q) < int'(fill_q)) ? LW'(delay_q) : fill_q;
			empty_q <= (n_i == 0) || (!sum_q && (int'(ch_q) >= int'(nch_q)));
		end
		if (cmd.aim) begin
			back_i = (int'(dmin_q) > int'(n_q)) ? int'(dmin_q) : int'(n_q);
			if (int'(pos_q) >= back_i) begin
				start_i = int'(pos_q) - back_i;
			end else begin
				start_i = int'(pos_q) + int'(len_q) - back_i;
			end
			addr_q <= AW'(start_i);
			k_q    <= '0;
		end else if (cmd.issue) begin
			k_q <= 7'(k_q + 1'b1);
			if (LW'(addr_q) + LW'(1) >= len_q) begin
				addr_q <= '0;
			end else begin
				addr_q <= AW'(addr_q + 1'b1);
			end
		end
	end

	assign last_now = empty_q || (7'(k_q + 1'b1) == n_q);
	assign st.last  = last_now;

	// stage 1: RAM read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			last_s1   <= last_now;
			empty_s1  <= empty_q;
			sum_s1    <= sum_q;
			ch_s1     <= ch_q;
			filled_s1 <= 13'(fill_q);
		end
	end

	// stage 2: select or add the lanes in two halves
	always_comb begin
		half0 = '0;
		half1 = '0;
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			if (!empty_s1 && (sum_s1 ? (c < int'(nch_q)) : (int'(ch_s1) == c))) begin
				if (c < H) begin
					half0 = half0 + HW'(rdata[c]);
				end else begin
					half1 = half1 + HW'(rdata[c]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			last_s2   <= last_s1;
			empty_s2  <= empty_s1;
			filled_s2 <= filled_s1;
			half0_s2  <= half0;
			half1_s2  <= half1;
		end
	end

	// stage 3: join halves and saturate to 27 bits
	always_comb begin
		sum_x = XW'(half0_s2) + XW'(half1_s2);
		if (sum_x > SAT_HI) begin
			sat = 27'(SAT_HI);
		end else if (sum_x < SAT_LO) begin
			sat = 27'(SAT_LO);
		end else begin
			sat = 27'(sum_x);
		end
	end

	// result queue
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_word   = fifo_q[rd_ptr_q];
	assign pend     = (FCW + 1)'(cnt_q) + (FCW + 1)'(v_s1) + (FCW + 1)'(v_s2);
	assign st.room  = (pend < (FCW + 1)'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (v_s2) begin
			fifo_q[wr_ptr_q] <= '{
				last:       last_s2,
				empty_res:  empty_s2,
				filled:     filled_s2,
				sample_out: sat
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= FPW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= FPW'(rd_ptr_q + 1'b1);
			end
			cnt_q <= FCW'(cnt_q + FCW'(v_s2) - FCW'(pop));
		end
	end

endmodule

/* sv/multichannel_history_ring_buffer.sv */
// Multichannel audio history ring. Write words (s_tuser kind write) store one channel's
// sample at the current frame position; s_tlast on a write closes the frame, advances the
// position (wrapping at buffer_length) and raises the fill count, saturating at
// buffer_length. Write and unused-kind words may arrive back to back. A read word
// returns n = min(count, filled, MAX_READ) results, oldest frame first, starting
// delay frames back (delay clamped to [n, filled]); each result is one channel's
// sample or the saturated sum over all active channels. A read passes the setup
// states (prep, aim), then issues one RAM read per cycle while the result queue has
// room, and holds the input until its last read issues; results pass the RAM output
// and stage 2 registers into a four-word queue that drains while the next words are
// taken. Each channel has its own RAM, so a channel sum reads every lane at once. A
// clear word, a write to buffer_length, and reset all start a clearing pass that
// zeroes the RAMs one frame row per cycle with s_tready low (configuration writes
// are still taken). Write configuration only while no read is in progress.
module multichannel_history_ring_buffer
	import mhrb_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_READ     = MAX_READ_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // channel[2:0], sample_in[26:3], delay[39:27],
	                               // count[46:40], sum_all[47]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // sample_out[26:0], filled[39:27]
	output logic        m_tuser,   // empty_res
	output logic        m_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	cmd_t      cmd;
	status_t   st;
	out_word_t m_word;
	item_t     item;
	logic      cfg_wr;
	logic      cfg_len_wr;

	// registers are always writable
	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign cfg_len_wr = cfg_wr && (cfg_index == REG_BUFFER_LENGTH);

	assign item = item_t'(s_tdata);

	// sequencer: accept, read setup, read issue, clearing pass
	mhrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.kind      (s_tuser),
		.cfg_len_wr(cfg_len_wr),
		.st        (st),
		.cmd       (cmd)
	);

	// channel RAMs, position and fill, read pipeline and result queue
	mhrb_dp #(
		.DEPTH       (DEPTH),
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_READ    (MAX_READ),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.kind     (s_tuser),
		.item     (item),
		.frame_end(s_tlast),
		.cfg_wr   (cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_word   (m_word)
	);

	assign m_tdata = {m_word.filled, m_word.sample_out};
	assign m_tuser = m_word.empty_res;
	assign m_tlast = m_word.last;

`ifndef SYNTHESIS
	// a write word never stalls the next one unless it coincides with a buffer_length write
	a_write_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == KIND_WRITE) && !cfg_len_wr) |=> s_tready)
		else $error("input stalled after a write word");

	// a clear word starts the clearing pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == KIND_CLEAR)) |=> !s_tready)
		else $error("input open right after a clear word");

	// an empty result is the only one of its read
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("empty result not marked last");

	// an empty result carries a zero sample
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[26:0] == 27'd0))
		else $error("empty result with nonzero sample");
`endif

endmodule
